// ----- rtl/core/fhc_pkg.sv -----
`default_nettype none

package fhc_pkg;

    // Frame layout and counter limits
    localparam logic [16:0] HEADER_BYTES  = 17'd12;
    localparam logic [16:0] CRC_START     = 17'd4;
    localparam logic [16:0] POS_MAX       = 17'h1FFFF;
    localparam logic [15:0] MIN_BYTES_RST = 16'd12;

    // CRC-16, reflected
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Queue depth, shared by the token queue and the result buffer
    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    // Configuration register indexes
    localparam logic REG_EXPECTED_MAGIC  = 1'b0;
    localparam logic REG_MIN_FRAME_BYTES = 1'b1;

    // Check status codes
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_TOO_SHORT    = 2'd1;
    localparam logic [1:0] ST_BAD_MAGIC    = 2'd2;
    localparam logic [1:0] ST_CRC_MISMATCH = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } t_item;

    typedef struct packed {
        logic [15:0] magic_word;
        logic [15:0] crc_word;
        logic [7:0]  frame_type;
        logic [15:0] frame_id;
        logic [7:0]  frame_sub_id;
        logic [15:0] sequence_number;
        logic [15:0] payload_length;
        logic [1:0]  check_status;
        logic        payload_complete;
        logic [7:0]  payload_byte;
        logic        payload_strobe;
        logic        frame_done;
    } t_result;

    // Captured header fields
    typedef struct packed {
        logic [15:0] magic;
        logic [15:0] crc;
        logic [7:0]  mtype;
        logic [15:0] id;
        logic [7:0]  sub_id;
        logic [15:0] seq;
        logic [15:0] length;
    } t_header;

    // Classified byte handed from the front end to the back end
    typedef struct packed {
        logic [7:0] data_byte;
        logic       crc_en;
        logic       strobe;
        logic       last;
        logic       full;
        logic       too_short;
        logic       magic_bad;
        logic       complete;
        t_header    hdr;
    } t_token;

    // One byte step of the reflected CRC
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fhc_front.sv -----
`default_nettype none

module fhc_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_wen,
    input  wire logic           i_cfg_index,
    input  wire logic [15:0]    i_cfg_data,
    input  wire logic           i_take,
    input  wire fhc_pkg::t_item i_item,
    output fhc_pkg::t_token     o_token
);

    logic [16:0]      r_pos;
    logic [16:0]      n_pos;
    fhc_pkg::t_header r_hdr;
    fhc_pkg::t_header n_hdr;
    logic [15:0]      r_magic_exp;
    logic [15:0]      r_min_bytes;
    logic [7:0]       w_b;

    assign w_b = i_item.data_byte;

    // Capture header bytes by offset
    always_comb begin
        n_hdr = r_hdr;
        unique case (r_pos)
            17'd0:   n_hdr.magic[7:0]   = w_b;
            17'd1:   n_hdr.magic[15:8]  = w_b;
            17'd2:   n_hdr.crc[7:0]     = w_b;
            17'd3:   n_hdr.crc[15:8]    = w_b;
            17'd4:   n_hdr.mtype        = w_b;
            17'd5:   n_hdr.id[7:0]      = w_b;
            17'd6:   n_hdr.id[15:8]     = w_b;
            17'd7:   n_hdr.sub_id       = w_b;
            17'd8:   n_hdr.seq[7:0]     = w_b;
            17'd9:   n_hdr.seq[15:8]    = w_b;
            17'd10:  n_hdr.length[7:0]  = w_b;
            17'd11:  n_hdr.length[15:8] = w_b;
            default: ;
        endcase
    end

    // Saturate the byte count
    assign n_pos = (r_pos != fhc_pkg::POS_MAX) ? (r_pos + 17'd1) : r_pos;

    // Classify the byte and pre-check the frame
    always_comb begin
        o_token.data_byte = w_b;
        o_token.crc_en    = (r_pos >= fhc_pkg::CRC_START);
        o_token.strobe    = (r_pos >= fhc_pkg::HEADER_BYTES) &&
                            (r_pos < (fhc_pkg::HEADER_BYTES + {1'b0, r_hdr.length}));
        o_token.last      = i_item.end_of_frame;
        o_token.full      = (n_pos >= fhc_pkg::HEADER_BYTES);
        o_token.too_short = (n_pos < fhc_pkg::CRC_START) || (n_pos < {1'b0, r_min_bytes});
        o_token.magic_bad = (n_hdr.magic != r_magic_exp);
        o_token.complete  = (n_pos >= (fhc_pkg::HEADER_BYTES + {1'b0, n_hdr.length}));
        o_token.hdr       = n_hdr;
    end

    // Hold frame state and configuration; clear the frame after its last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_hdr       <= '0;
            r_magic_exp <= '0;
            r_min_bytes <= fhc_pkg::MIN_BYTES_RST;
        end else begin
            if (i_take) begin
                if (i_item.end_of_frame) begin
                    r_pos <= '0;
                    r_hdr <= '0;
                end else begin
                    r_pos <= n_pos;
                    r_hdr <= n_hdr;
                end
            end
            if (i_cfg_wen) begin
                unique case (i_cfg_index)
                    fhc_pkg::REG_EXPECTED_MAGIC:  r_magic_exp <= i_cfg_data;
                    fhc_pkg::REG_MIN_FRAME_BYTES: r_min_bytes <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/fhc_queue.sv -----
`default_nettype none

module fhc_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire fhc_pkg::t_token i_token,
    output logic                 o_full,
    output logic                 o_valid,
    output fhc_pkg::t_token      o_token,
    input  wire logic            i_pop
);

    fhc_pkg::t_token r_mem [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;
    logic            w_wr;
    logic            w_rd;

    assign o_full  = (r_count == fhc_pkg::QUEUE_DEPTH);
    assign o_valid = (r_count != 2'd0);
    assign o_token = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wptr <= !r_wptr;
            end
            if (w_rd) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    // Store the item
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_token;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/fhc_back.sv -----
`default_nettype none

module fhc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire fhc_pkg::t_token i_token,
    output logic                 o_q_pop,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output fhc_pkg::t_result     o_result
);

    logic [15:0]      r_crc;
    logic [15:0]      w_crc;
    fhc_pkg::t_result r_buf [2];
    fhc_pkg::t_result w_res;
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic             w_take;
    logic             w_rd;
    logic             w_show;

    assign w_take   = i_q_valid && (r_count != fhc_pkg::QUEUE_DEPTH);
    assign o_q_pop  = w_take;
    assign o_empty  = (r_count == 2'd0);
    assign w_rd     = i_pop && !o_empty;
    assign o_result = r_buf[r_rptr];

    // Update the running CRC from offset four on
    assign w_crc = i_token.crc_en ? fhc_pkg::crc16_byte(r_crc, i_token.data_byte) : r_crc;

    // Build the result item
    assign w_show = i_token.last && i_token.full;
    always_comb begin
        w_res.magic_word       = w_show ? i_token.hdr.magic  : 16'h0000;
        w_res.crc_word         = w_show ? i_token.hdr.crc    : 16'h0000;
        w_res.frame_type       = w_show ? i_token.hdr.mtype  : 8'h00;
        w_res.frame_id         = w_show ? i_token.hdr.id     : 16'h0000;
        w_res.frame_sub_id     = w_show ? i_token.hdr.sub_id : 8'h00;
        w_res.sequence_number  = w_show ? i_token.hdr.seq    : 16'h0000;
        w_res.payload_length   = w_show ? i_token.hdr.length : 16'h0000;
        w_res.payload_complete = w_show && i_token.complete;
        w_res.payload_byte     = i_token.strobe ? i_token.data_byte : 8'h00;
        w_res.payload_strobe   = i_token.strobe;
        w_res.frame_done       = i_token.last;
        priority if (!i_token.last) begin
            w_res.check_status = fhc_pkg::ST_OK;
        end else if (i_token.too_short) begin
            w_res.check_status = fhc_pkg::ST_TOO_SHORT;
        end else if (i_token.magic_bad) begin
            w_res.check_status = fhc_pkg::ST_BAD_MAGIC;
        end else if (i_token.hdr.crc != w_crc) begin
            w_res.check_status = fhc_pkg::ST_CRC_MISMATCH;
        end else begin
            w_res.check_status = fhc_pkg::ST_OK;
        end
    end

    // Advance CRC and result buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= fhc_pkg::CRC_INIT;
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_take) begin
                r_crc  <= i_token.last ? fhc_pkg::CRC_INIT : w_crc;
                r_wptr <= !r_wptr;
            end
            if (w_rd) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, w_take} - {1'b0, w_rd};
        end
    end

    // Store the result item
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_buf[r_wptr] <= w_res;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/frame_header_check_crc16.sv -----
// Frame header checker with CRC-16 (reflected, poly 0xA001, init 0xFFFF).
// Input channel: one frame byte per item with an end-of-frame mark; an item
// is taken at a clock edge with push high and full low.
// Result channel: one result item per input item; the oldest result sits on
// o_result while empty is low and leaves at an edge with pop high.
// Configuration: i_cfg_wen writes i_cfg_data to register i_cfg_index
// (0 expected magic, 1 minimum frame bytes); the user writes only while the
// block is idle, which the block itself does not enforce. An accepted item
// goes into the token queue; once the result buffer has room, the back end
// writes its result there, and o_result reads from it. Throughput: one byte
// per cycle while full is low; the front end classifies each byte on entry.
// A two-entry token queue separates front and back, and a two-entry result
// buffer separates the back end from the receiver. When the receiver stops
// popping, the result buffer fills, then the token queue, then full rises;
// no item is lost.
// Reset (synchronous, active low) empties both queues, clears the frame
// state, sets the CRC to 0xFFFF, expected magic to 0 and minimum bytes to 12.
`default_nettype none

module frame_header_check_crc16 (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire fhc_pkg::t_item i_item,
    output logic                empty,
    input  wire logic           pop,
    output fhc_pkg::t_result    o_result,
    input  wire logic           i_cfg_wen,
    input  wire logic           i_cfg_index,
    input  wire logic [15:0]    i_cfg_data
);

    fhc_pkg::t_token w_tok_in;
    fhc_pkg::t_token w_tok_out;
    logic            w_q_full;
    logic            w_q_valid;
    logic            w_q_pop;
    logic            w_take;

    assign full   = w_q_full;
    assign w_take = push && !w_q_full;

    fhc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (w_take),
        .i_item      (i_item),
        .o_token     (w_tok_in)
    );

    fhc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take),
        .i_token (w_tok_in),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_token (w_tok_out),
        .i_pop   (w_q_pop)
    );

    fhc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_token   (w_tok_out),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

`ifndef SYNTHESIS
    // Both sides come out of reset idle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // A result that ends no frame carries no summary
    a_mid_frame_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.frame_done) |->
        (o_result.check_status == fhc_pkg::ST_OK && !o_result.payload_complete &&
         o_result.payload_length == 16'h0000 && o_result.magic_word == 16'h0000))
        else $error("summary fields set on a mid-frame result");

    // Payload byte is zero without its strobe
    a_strobe_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.payload_strobe) |-> (o_result.payload_byte == 8'h00))
        else $error("payload byte set without strobe");

    // The back end only drains a non-empty token queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("token queue popped while empty");
`endif

endmodule

`default_nettype wire
